FILE: hw/rtl/tlspq_pkg.sv
package tlspq_pkg;

  // Number of priority levels; level index 0 is served first.
  localparam int unsigned NumLevels = 3;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_ENQ     = 3'd0,
    ST_DEQ     = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_FULL    = 3'd3,
    ST_BADPRIO = 3'd4
  } tlspq_status_e;

  // Operation modes of an input word.
  typedef enum logic {
    MODE_ENQ = 1'b0,
    MODE_DEQ = 1'b1
  } tlspq_mode_e;

  // Decision of the queue control for the word in the input register.
  typedef struct packed {
    tlspq_status_e status;
    logic [1:0]    served_level;
    logic          wr_en;
    logic          rd_en;
  } tlspq_res_t;

endpackage

FILE: hw/rtl/tlspq_ram.sv
module tlspq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 48
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: hw/rtl/tlspq_ctrl.sv
module tlspq_ctrl #(
  parameter int unsigned LEVEL_DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  fire_i,
  input  logic                                  mode_i,
  input  logic [1:0]                            priority_level_i,
  input  logic [1:0]                            start_level_i,
  output tlspq_pkg::tlspq_res_t                 res_o,
  output logic [$clog2(3*LEVEL_DEPTH)-1:0]      wr_addr_o,
  output logic [$clog2(3*LEVEL_DEPTH)-1:0]      rd_addr_o,
  output logic [$clog2(3*LEVEL_DEPTH+1)-1:0]    total_next_o
);
  import tlspq_pkg::*;

  localparam int unsigned CntW  = $clog2(LEVEL_DEPTH + 1);
  localparam int unsigned PtrW  = $clog2(LEVEL_DEPTH);
  localparam int unsigned AddrW = $clog2(3 * LEVEL_DEPTH);
  localparam int unsigned TotW  = $clog2(3 * LEVEL_DEPTH + 1);

  logic [CntW-1:0] cnt_q  [NumLevels];
  logic [CntW-1:0] cnt_d  [NumLevels];
  logic [PtrW-1:0] head_q [NumLevels];
  logic [PtrW-1:0] head_d [NumLevels];
  logic [PtrW-1:0] tail_q [NumLevels];
  logic [PtrW-1:0] tail_d [NumLevels];
  logic [TotW-1:0] total_q;
  logic [TotW-1:0] total_d;

  logic [1:0]      enq_lv;
  logic [CntW-1:0] enq_cnt;
  logic [PtrW-1:0] enq_ptr;
  logic            deq_found;
  logic [1:0]      deq_lv;
  logic [PtrW-1:0] deq_ptr;
  tlspq_res_t      res;

  // Pick the target level of an enqueue and the first non-empty level of a dequeue.
  always_comb begin
    enq_lv    = priority_level_i - 2'd1;
    enq_cnt   = '0;
    enq_ptr   = '0;
    deq_found = 1'b0;
    deq_lv    = '0;
    deq_ptr   = '0;
    for (int l = 0; l < NumLevels; l++) begin
      if (enq_lv == 2'(l)) begin
        enq_cnt = cnt_q[l];
        enq_ptr = tail_q[l];
      end
      if (!deq_found && (2'(l) >= start_level_i) && (cnt_q[l] != '0)) begin
        deq_found = 1'b1;
        deq_lv    = 2'(l);
        deq_ptr   = head_q[l];
      end
    end
  end

  // Decide the outcome of the word.
  always_comb begin
    res              = '0;
    res.status       = ST_EMPTY;
    if (tlspq_mode_e'(mode_i) == MODE_ENQ) begin
      if (priority_level_i == 2'd0) begin
        res.status = ST_BADPRIO;
      end else if (enq_cnt == CntW'(LEVEL_DEPTH)) begin
        res.status = ST_FULL;
      end else begin
        res.status = ST_ENQ;
        res.wr_en  = 1'b1;
      end
    end else if (deq_found) begin
      res.status       = ST_DEQ;
      res.served_level = deq_lv;
      res.rd_en        = 1'b1;
    end
  end

  assign res_o     = res;
  assign wr_addr_o = AddrW'(enq_lv) * AddrW'(LEVEL_DEPTH) + AddrW'(enq_ptr);
  assign rd_addr_o = AddrW'(deq_lv) * AddrW'(LEVEL_DEPTH) + AddrW'(deq_ptr);

  // Advance pointers and counts of the level that is touched.
  always_comb begin
    total_d = total_q;
    for (int l = 0; l < NumLevels; l++) begin
      cnt_d[l]  = cnt_q[l];
      head_d[l] = head_q[l];
      tail_d[l] = tail_q[l];
      if (fire_i && res.wr_en && (enq_lv == 2'(l))) begin
        tail_d[l] = (tail_q[l] == PtrW'(LEVEL_DEPTH - 1)) ? '0 : tail_q[l] + 1'b1;
        cnt_d[l]  = cnt_q[l] + 1'b1;
      end
      if (fire_i && res.rd_en && (deq_lv == 2'(l))) begin
        head_d[l] = (head_q[l] == PtrW'(LEVEL_DEPTH - 1)) ? '0 : head_q[l] + 1'b1;
        cnt_d[l]  = cnt_q[l] - 1'b1;
      end
    end
    if (fire_i && res.wr_en) begin
      total_d = total_q + 1'b1;
    end else if (fire_i && res.rd_en) begin
      total_d = total_q - 1'b1;
    end
  end

  assign total_next_o = total_d;

  // Queue control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      for (int l = 0; l < NumLevels; l++) begin
        cnt_q[l]  <= '0;
        head_q[l] <= '0;
        tail_q[l] <= '0;
      end
    end else begin
      total_q <= total_d;
      for (int l = 0; l < NumLevels; l++) begin
        cnt_q[l]  <= cnt_d[l];
        head_q[l] <= head_d[l];
        tail_q[l] <= tail_d[l];
      end
    end
  end

`ifndef NO_ASSERTIONS
  // The total always equals the sum of the level counts.
  a_total_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q == TotW'(cnt_q[0]) + TotW'(cnt_q[1]) + TotW'(cnt_q[2]))
    else $error("total count differs from sum of level counts");

  for (genvar g = 0; g < NumLevels; g++) begin : g_chk
    // No level ever holds more than its depth.
    a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
      cnt_q[g] <= CntW'(LEVEL_DEPTH))
      else $error("level count exceeds depth");

    // The pointer distance matches the count, modulo the depth.
    a_ptr_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (((tail_q[g] >= head_q[g]) ? (CntW'(tail_q[g]) - CntW'(head_q[g]))
        : (CntW'(tail_q[g]) + CntW'(LEVEL_DEPTH) - CntW'(head_q[g])))
       == ((cnt_q[g] == CntW'(LEVEL_DEPTH)) ? CntW'(0) : cnt_q[g])))
      else $error("head and tail pointers disagree with level count");
  end
`endif

endmodule

FILE: hw/rtl/three_level_strict_priority_queue_unit.sv
// Three-level strict priority queue. Each enqueue word appends its payload to the
// FIFO of its priority (1 high, 2 medium, 3 low; 0 is rejected with status 4, a full
// level with status 3). Each dequeue word removes the head of the first non-empty
// level at or below start_level, or answers status 2. Every accepted word gives one
// result word; it passes through the input register, then through the result register
// and the registered read port of the payload RAM. One word is taken per clock while
// the output is not stalled; the shared payload RAM of 3*LEVEL_DEPTH entries has a
// single write and a single read port. While a finished result waits at a stalled
// output, the input register takes one more word and then stalls the input. Payload
// storage starts undefined; counts and pointers are cleared by reset.
module three_level_strict_priority_queue_unit #(
  parameter int unsigned LEVEL_DEPTH   = 16,
  parameter int unsigned PAYLOAD_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [1:0]  priority_level_i,
  input  logic [1:0]  start_level_i,
  input  logic [31:0] payload_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [31:0] out_payload_o,
  output logic [1:0]  served_level_o,
  output logic [5:0]  waiting_total_o
);
  import tlspq_pkg::*;

  localparam int unsigned StoreW = (PAYLOAD_WIDTH < 32) ? PAYLOAD_WIDTH : 32;
  localparam int unsigned AddrW  = $clog2(3 * LEVEL_DEPTH);
  localparam int unsigned TotW   = $clog2(3 * LEVEL_DEPTH + 1);

  logic              in_valid_q;
  logic              mode_q;
  logic [1:0]        prio_q;
  logic [1:0]        start_q;
  logic [StoreW-1:0] payload_q;

  logic              out_valid_q;
  tlspq_status_e     status_q;
  logic [1:0]        served_q;
  logic [5:0]        total_q;
  logic              deq_q;

  logic              advance;
  logic              fire;
  tlspq_res_t        res;
  logic [AddrW-1:0]  wr_addr;
  logic [AddrW-1:0]  rd_addr;
  logic [TotW-1:0]   total_next;
  logic [StoreW-1:0] rd_data;

  // Handshake: the result register moves when empty or taken.
  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      mode_q    <= mode_i;
      prio_q    <= priority_level_i;
      start_q   <= start_level_i;
      payload_q <= StoreW'(payload_i);
    end
  end

  // Level bookkeeping and decision.
  tlspq_ctrl #(
    .LEVEL_DEPTH(LEVEL_DEPTH)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .fire_i          (fire),
    .mode_i          (mode_q),
    .priority_level_i(prio_q),
    .start_level_i   (start_q),
    .res_o           (res),
    .wr_addr_o       (wr_addr),
    .rd_addr_o       (rd_addr),
    .total_next_o    (total_next)
  );

  // Payload storage; the read data register serves as the payload result stage.
  tlspq_ram #(
    .Width(StoreW),
    .Depth(3 * LEVEL_DEPTH)
  ) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (fire && res.wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(payload_q),
    .rd_en_i  (fire && res.rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q <= res.status;
      served_q <= res.served_level;
      total_q  <= 6'(total_next);
      deq_q    <= res.rd_en;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign served_level_o  = served_q;
  assign waiting_total_o = total_q;
  assign out_payload_o   = deq_q ? 32'(rd_data) : 32'd0;

endmodule
